[rtl/core/frm_pkg.sv]
// Frame rate meter package: status codes, register indexes and arithmetic constants.
// No dependencies; used by the interfaces and by every module of the meter.
`timescale 1ns / 1ps
package frm_pkg;

  typedef enum logic [2:0] {
    ST_RATE      = 3'd0,
    ST_BASELINE  = 3'd1,
    ST_ZERO_TIME = 3'd2,
    ST_WARMUP    = 3'd3,
    ST_OVER      = 3'd4,
    ST_DISABLED  = 3'd5,
    ST_LOST      = 3'd6
  } frm_status_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd2;

  localparam int CNT_W   = 32;
  localparam int TIME_W  = 64;
  localparam int SCALE_W = 24;
  localparam int PROD_W  = CNT_W + SCALE_W;
  localparam int TENTH_W = 16;
  localparam int FPS_W   = 13;

  localparam logic [SCALE_W-1:0] SCALE = 24'd10000000;

  localparam logic [TENTH_W:0]  FPS_ROUND = 17'd5;
  localparam logic [TENTH_W-1:0] FPS_RECIP = 16'd52429;
  localparam int FPS_SHIFT = 19;
  localparam int FPS_PROD_W = 2 * TENTH_W + 1;

  typedef struct packed {
    logic               big;
    logic [TENTH_W-1:0] quo;
  } frm_quo_t;

endpackage

[rtl/core/frm_if.sv]
// Valid/ready channel interfaces for meter samples and results.
// Depends on frm_pkg for field widths and the status type.
`timescale 1ns / 1ps
interface frm_in_if
  import frm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  counter_value;
  logic [TIME_W-1:0] time_us;
  logic              source_lost;

  modport source (output valid, counter_value, time_us, source_lost, input ready);
  modport sink (input valid, counter_value, time_us, source_lost, output ready);
endinterface

interface frm_out_if
  import frm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             rate_valid;
  logic [FPS_W-1:0] rate_fps;
  frm_status_t      status;

  modport source (output valid, rate_valid, rate_fps, status, input ready);
  modport sink (input valid, rate_valid, rate_fps, status, output ready);
endinterface

[rtl/core/frame_rate_meter_unit.sv]
// Frame rate meter top level: sample decode, rate state, sequencing and result register.
// Depends on frm_pkg, frm_if, frm_serial_mul and frm_serial_div.
//
//   channel | dir | payload                              | handshake
//   in_ch   | in  | counter_value, time_us, source_lost  | valid/ready
//   out_ch  | out | rate_valid, rate_fps, status         | valid/ready
//   cfg     | in  | cfg_we, cfg_index, cfg_data          | write enable only
//
// A sample that yields a rate goes, after acceptance, through loading the multiplier,
// 24 multiply steps, loading the divider, 56 divide steps, then compare and rounding,
// the fps step and the output register (the fps step is skipped when over the limit).
// Every other sample goes from acceptance through the emit state to the output register.
// Samples are taken only when the sequencer is idle, which it becomes as the previous result
// is loaded; while the output register still holds an unaccepted item, a finished result
// waits and input ready stays low.
// Reset (synchronous, rst high) restores the register defaults and clears the baseline.
`timescale 1ns / 1ps
module frame_rate_meter_unit
  import frm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  frm_in_if.sink                in_ch,
  frm_out_if.source             out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_CHECK,
    S_FPS,
    S_EMIT
  } state_t;

  state_t state;

  logic               sampling_enabled;
  logic [3:0]         warmup_count;
  logic [TENTH_W-1:0] max_tenths;

  logic               have_baseline;
  logic [3:0]         warmup_left;
  logic [CNT_W-1:0]   last_counter;
  logic [TIME_W-1:0]  last_time;

  logic [CNT_W-1:0]   delta;
  logic [TIME_W-1:0]  elapsed;
  logic [TENTH_W:0]   rounded;
  logic               res_valid;
  logic [FPS_W-1:0]   res_fps;
  frm_status_t        res_status;

  logic               mul_start;
  logic               mul_done;
  logic [PROD_W-1:0]  product;
  logic               div_done;
  frm_quo_t           quo;

  logic                  accept;
  logic                  mul_go;
  logic                  emit_go;
  logic [FPS_PROD_W-1:0] fps_prod;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign mul_go      = accept && sampling_enabled && !in_ch.source_lost && have_baseline &&
                       (in_ch.time_us != last_time) && (warmup_left == 4'd0);
  assign emit_go     = (state == S_EMIT) && (!out_ch.valid || out_ch.ready);
  assign fps_prod    = FPS_PROD_W'(rounded) * FPS_PROD_W'(FPS_RECIP);

  frm_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .delta   (delta),
    .done    (mul_done),
    .product (product)
  );

  frm_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_done),
    .dividend (product),
    .divisor  (elapsed),
    .done     (div_done),
    .result   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      sampling_enabled <= 1'b0;
      warmup_count     <= 4'd1;
      max_tenths       <= 16'd2400;
      have_baseline    <= 1'b0;
      warmup_left      <= 4'd1;
      last_counter     <= '0;
      last_time        <= '0;
      mul_start        <= 1'b0;
      out_ch.valid     <= 1'b0;
    end else begin
      mul_start <= mul_go;
      if (emit_go) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE: begin
            sampling_enabled <= cfg_data[0];
            have_baseline    <= 1'b0;
            warmup_left      <= warmup_count;
            last_counter     <= '0;
            last_time        <= '0;
          end
          CFG_WARMUP: warmup_count <= cfg_data[3:0];
          CFG_MAX:    max_tenths <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            res_valid <= 1'b0;
            res_fps   <= '0;
            state     <= S_EMIT;
            if (!sampling_enabled) begin
              res_status <= ST_DISABLED;
            end else if (in_ch.source_lost) begin
              res_status    <= ST_LOST;
              have_baseline <= 1'b0;
              warmup_left   <= warmup_count;
              last_counter  <= '0;
              last_time     <= '0;
            end else if (!have_baseline) begin
              res_status    <= ST_BASELINE;
              have_baseline <= 1'b1;
              last_counter  <= in_ch.counter_value;
              last_time     <= in_ch.time_us;
            end else if (in_ch.time_us == last_time) begin
              res_status <= ST_ZERO_TIME;
            end else begin
              last_counter <= in_ch.counter_value;
              last_time    <= in_ch.time_us;
              if (warmup_left != 4'd0) begin
                warmup_left <= warmup_left - 4'd1;
                res_status  <= ST_WARMUP;
              end else begin
                delta     <= in_ch.counter_value - last_counter;
                elapsed   <= in_ch.time_us - last_time;
                state     <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (quo.big || (quo.quo > max_tenths)) begin
            res_status <= ST_OVER;
            state      <= S_EMIT;
          end else begin
            rounded <= {1'b0, quo.quo} + FPS_ROUND;
            state   <= S_FPS;
          end
        end
        S_FPS: begin
          res_valid  <= 1'b1;
          res_fps    <= fps_prod[FPS_SHIFT + FPS_W - 1:FPS_SHIFT];
          res_status <= ST_RATE;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_ch.rate_valid <= res_valid;
            out_ch.rate_fps   <= res_fps;
            out_ch.status     <= res_status;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/frm_serial_mul.sv]
// Shift-and-add multiplier of the counter delta by the fixed scale, one scale bit a cycle.
// Depends on frm_pkg for widths and the scale constant.
`timescale 1ns / 1ps
module frm_serial_mul
  import frm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  delta,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  localparam int STEP_W = $clog2(SCALE_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SCALE_W-1:0] mplier;
  logic [PROD_W-1:0] mcand;
  logic [PROD_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == STEP_W'(SCALE_W - 1));
      if (start) begin
        busy   <= 1'b1;
        step   <= '0;
        mplier <= SCALE;
        mcand  <= PROD_W'(delta);
        acc    <= '0;
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[SCALE_W-1:1]};
        step   <= step + 1'b1;
        if (step == STEP_W'(SCALE_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign product = acc;

endmodule

[rtl/core/frm_serial_div.sv]
// Restoring divider, one quotient bit a cycle, with a narrow quotient and a sticky overflow flag.
// Depends on frm_pkg for widths and the quotient struct.
`timescale 1ns / 1ps
module frm_serial_div
  import frm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output frm_quo_t          result
);

  localparam int STEP_W = $clog2(PROD_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [PROD_W-1:0] dvd;
  logic [TIME_W-1:0] dsr;
  logic [TIME_W-1:0] rem;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              fits;

  assign trial = {rem, dvd[PROD_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == STEP_W'(PROD_W - 1));
      if (start) begin
        busy       <= 1'b1;
        step       <= '0;
        dvd        <= dividend;
        dsr        <= divisor;
        rem        <= '0;
        result.quo <= '0;
        result.big <= 1'b0;
      end else if (busy) begin
        rem        <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
        dvd        <= {dvd[PROD_W-2:0], 1'b0};
        result.quo <= {result.quo[TENTH_W-2:0], fits};
        result.big <= result.big | result.quo[TENTH_W-1];
        step       <= step + 1'b1;
        if (step == STEP_W'(PROD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[tb/sv/tb_frame_rate_meter_unit.sv]
// Testbench for frame_rate_meter_unit: drives counter/time samples and register writes,
// predicts every result in a behavioral model of the meter and checks it field by field.
// Depends on frm_pkg, frm_if (frm_in_if, frm_out_if) and the meter RTL.
`timescale 1ns / 1ps
module tb_frame_rate_meter_unit;
  import frm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam longint unsigned TENTHS_SCALE = 64'd10000000;
  localparam longint unsigned TENTHS_MAX = 64'hFFFF_FFFF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic             rate_valid;
    logic [FPS_W-1:0] rate_fps;
    logic [2:0]       status;
  } meter_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  frm_in_if  in_ch ();
  frm_out_if out_ch ();

  frame_rate_meter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Meter model: registers and rate state
  logic              cfg_enabled;
  logic [3:0]        cfg_warmup;
  logic [15:0]       cfg_max;
  logic              base_valid;
  logic [3:0]        warm_left;
  logic [CNT_W-1:0]  base_count;
  logic [TIME_W-1:0] base_time;

  meter_result_t pending_results[$];

  int  errors;
  int  n_checked;
  int  n_rates;
  int  n_writes;
  int  n_random;
  bit  idle_on;
  bit  rx_stalls_on;
  int  hold_request;
  int  stall_left;

  // Sample stream that random items advance
  logic [CNT_W-1:0]  strm_count;
  logic [TIME_W-1:0] strm_time;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function void clear_meter();
    base_valid = 1'b0;
    warm_left  = cfg_warmup;
    base_count = '0;
    base_time  = '0;
  endfunction

  function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_ENABLE: begin
        cfg_enabled = value[0];
        clear_meter();
      end
      CFG_WARMUP: cfg_warmup = value[3:0];
      CFG_MAX:    cfg_max = value[15:0];
      default: ;
    endcase
  endfunction

  function automatic meter_result_t predict_meter(logic [CNT_W-1:0] cnt,
                                                  logic [TIME_W-1:0] tus, logic lost);
    meter_result_t     r;
    logic [TIME_W-1:0] elapsed;
    logic [CNT_W-1:0]  delta;
    logic [63:0]       tenths;
    r = '0;
    r.status = ST_RATE;
    if (!cfg_enabled) begin
      r.status = ST_DISABLED;
    end else if (lost) begin
      clear_meter();
      r.status = ST_LOST;
    end else if (!base_valid) begin
      base_valid = 1'b1;
      base_count = cnt;
      base_time  = tus;
      r.status = ST_BASELINE;
    end else begin
      elapsed = tus - base_time;
      if (elapsed == 0) begin
        r.status = ST_ZERO_TIME;
      end else begin
        delta  = cnt - base_count;
        tenths = (64'(delta) * TENTHS_SCALE) / elapsed;
        if (tenths > TENTHS_MAX) tenths = TENTHS_MAX;
        base_count = cnt;
        base_time  = tus;
        if (warm_left != 0) begin
          warm_left = warm_left - 4'd1;
          r.status = ST_WARMUP;
        end else if (tenths > 64'(cfg_max)) begin
          r.status = ST_OVER;
        end else begin
          r.rate_valid = 1'b1;
          r.rate_fps = FPS_W'((tenths + 64'd5) / 64'd10);
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_sample(logic [CNT_W-1:0] cnt, logic [TIME_W-1:0] tus, logic lost);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.counter_value <= cnt;
    in_ch.time_us       <= tus;
    in_ch.source_lost   <= lost;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_meter(cnt, tus, lost));
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    apply_reg(idx, value);
    n_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_sample();
    int          r;
    logic [63:0] elapsed;
    logic [63:0] tgt;
    logic [63:0] delta;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      if ($urandom_range(0, 9) == 0) elapsed = 64'($urandom);
      else elapsed = 64'($urandom_range(1000, 2000000));
      if (elapsed == 0) elapsed = 64'd1;
      tgt   = 64'($urandom_range(0, int'(cfg_max) + int'(cfg_max) / 8 + 20));
      delta = (tgt * elapsed) / TENTHS_SCALE;
      strm_count = strm_count + delta[CNT_W-1:0];
      strm_time  = strm_time + elapsed;
      send_sample(strm_count, strm_time, 1'b0);
    end else if (r < 84) begin
      strm_count = strm_count + CNT_W'($urandom_range(0, 50));
      send_sample(strm_count, strm_time, 1'b0);
    end else if (r < 89) begin
      send_sample($urandom, {$urandom, $urandom}, 1'b1);
    end else if (r < 93) begin
      strm_count = $urandom;
      strm_time  = {$urandom, $urandom};
      send_sample(strm_count, strm_time, 1'b0);
    end else if (r < 96) begin
      strm_time = strm_time - TIME_W'($urandom_range(1, 1000));
      send_sample(strm_count, strm_time, 1'b0);
    end else begin
      strm_count = strm_count + $urandom;
      strm_time  = strm_time + TIME_W'($urandom_range(1, 10));
      send_sample(strm_count, strm_time, 1'b0);
    end
  endtask

  task automatic test_disabled_samples();
    send_sample(32'h0000_1234, 64'd50, 1'b0);
    send_sample(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_rate_sequence();
    write_reg(CFG_ENABLE, 16'h0001);
    send_sample(32'd100, 64'd1000, 1'b0);
    send_sample(32'd130, 64'd1000, 1'b0);
    send_sample(32'd160, 64'd1001000, 1'b0);
    send_sample(32'd220, 64'd2001000, 1'b0);
    send_sample(32'd1220, 64'd3001000, 1'b0);
    send_sample(32'd1219, 64'd3001001, 1'b0);
    send_sample(32'hFFFF_FFF0, 64'd4001001, 1'b0);
    send_sample(32'h0000_000E, 64'd5001001, 1'b0);
    send_sample(32'h0000_000F, 64'd5001000, 1'b0);
    send_sample(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 64'd0, 1'b0);
    send_sample(32'd5, 64'd7, 1'b1);
    wait_idle();
  endtask

  task automatic test_register_effects();
    write_reg(CFG_WARMUP, 16'hFFF0);
    send_sample(32'd10, 64'd100, 1'b0);
    send_sample(32'd20, 64'd1000100, 1'b0);
    send_sample(32'd30, 64'd2000100, 1'b0);
    wait_idle();
    write_reg(CFG_MAX, 16'hFFFF);
    send_sample(32'd65565, 64'd12000100, 1'b0);
    wait_idle();
    write_reg(CFG_MAX, 16'h0000);
    send_sample(32'd65565, 64'd13000100, 1'b0);
    send_sample(32'd65566, 64'd14000100, 1'b0);
    wait_idle();
    write_reg(CFG_NONE, 16'hFFFF);
    write_reg(CFG_ENABLE, 16'hFFFE);
    send_sample(32'd1, 64'd1, 1'b1);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    write_reg(CFG_WARMUP, 16'h0000);
    write_reg(CFG_MAX, 16'hFFFF);
    write_reg(CFG_ENABLE, 16'h0001);
    idle_on = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (20) send_random_sample();
    wait_idle();
  endtask

  task automatic test_random_phases();
    int                    n;
    int                    r;
    bit                    enable_first;
    logic [CFG_DATA_W-1:0] en_data;
    logic [CFG_DATA_W-1:0] wu_data;
    logic [CFG_DATA_W-1:0] max_data;
    while (n_random < RANDOM_ITEMS) begin
      wait_idle();
      en_data = 16'($urandom);
      en_data[0] = ($urandom_range(0, 7) != 0);
      wu_data = 16'($urandom);
      r = $urandom_range(0, 3);
      wu_data[3:0] = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : 4'($urandom_range(0, 15));
      r = $urandom_range(0, 7);
      max_data = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                 (r == 2) ? 16'($urandom) : 16'($urandom_range(20, 3000));
      enable_first = $urandom_range(0, 1);
      if (enable_first) write_reg(CFG_ENABLE, en_data);
      write_reg(CFG_WARMUP, wu_data);
      write_reg(CFG_MAX, max_data);
      if (!enable_first && $urandom_range(0, 3) != 0) write_reg(CFG_ENABLE, en_data);
      idle_on      = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(30, 120);
      repeat (n) send_random_sample();
      n_random += n;
    end
    wait_idle();
  endtask

  // Output side: random stalls plus the long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_request > 0) begin
      stall_left = hold_request - 1;
      hold_request = 0;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left = rx_stalls_on ? pick_gap() : 0;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    meter_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result rate_valid=%0d rate_fps=%0d status=%0d", $time,
                 out_ch.rate_valid, out_ch.rate_fps, out_ch.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.rate_valid) n_rates++;
        if (out_ch.rate_valid !== want.rate_valid) begin
          $display("%0t: rate_valid expected %0d actual %0d", $time, want.rate_valid,
                   out_ch.rate_valid);
          errors++;
        end
        if (out_ch.rate_fps !== want.rate_fps) begin
          $display("%0t: rate_fps expected %0d actual %0d", $time, want.rate_fps,
                   out_ch.rate_fps);
          errors++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_ch.status);
          errors++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("tb_frame_rate_meter_unit NOT OK");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.counter_value = '0;
    in_ch.time_us = '0;
    in_ch.source_lost = 1'b0;
    out_ch.ready = 1'b0;
    errors = 0;
    n_checked = 0;
    n_rates = 0;
    n_writes = 0;
    n_random = 0;
    idle_on = 1'b1;
    rx_stalls_on = 1'b1;
    hold_request = 0;
    strm_count = $urandom;
    strm_time = {$urandom, $urandom};
    cfg_enabled = 1'b0;
    cfg_warmup = 4'd1;
    cfg_max = 16'd2400;
    clear_meter();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled_samples();
    test_rate_sequence();
    test_register_effects();
    test_output_backpressure();
    test_random_phases();

    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Checked %0d results (%0d reported rates) from %0d random samples,",
             n_checked, n_rates, n_random);
    $display("with %0d register writes and one long output hold-off.", n_writes);
    if (errors == 0) begin
      $display("tb_frame_rate_meter_unit OK");
    end else begin
      $display("tb_frame_rate_meter_unit NOT OK");
    end
    $finish;
  end

endmodule
